// ===== hdl/meter_register_poll_controller_assert.svh =====
// Assertion macros for the meter register poll controller.
// Used by the top level only; needs nothing else.
`ifndef METER_REGISTER_POLL_CONTROLLER_ASSERT_SVH
`define METER_REGISTER_POLL_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define MRPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrpc assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define MRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrpc assertion failed");
`else
`define MRPC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/mrpc_pkg.sv =====
// Shared types and constants of the meter register poll controller.
// No dependencies; used by every module of the block.
`default_nettype none

package mrpc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_COMMAND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_ADDR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_ADDR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE    = 3'd6;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_FRAME   = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;

    localparam logic [1:0] PHASE_IDLE     = 2'd0;
    localparam logic [1:0] PHASE_ARMED    = 2'd1;
    localparam logic [1:0] PHASE_COUNTING = 2'd2;

    localparam logic [7:0] CHECKSUM_BASE = 8'hFF;

    typedef struct packed {
        logic [7:0]  read_command;
        logic [7:0]  current_reg_addr;
        logic [7:0]  voltage_reg_addr;
        logic [15:0] timeout_ticks;
        logic [15:0] poll_period_ticks;
        logic [2:0]  max_retries;
        logic        auto_enable;
    } cfg_t;

    typedef struct packed {
        logic        busy;
        logic [1:0]  timer_phase;
        logic [15:0] timeout_count;
        logic        timeout_flag;
        logic [2:0]  retry_count;
        logic [7:0]  pending_addr;
        logic        poll_slot;
        logic [15:0] poll_timer;
    } state_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_high;
        logic [7:0] data_mid;
        logic [7:0] data_low;
        logic [7:0] frame_checksum;
    } item_t;

    typedef struct packed {
        logic        request_valid;
        logic [7:0]  request_command;
        logic [7:0]  request_addr;
        logic        value_valid;
        logic        value_channel;
        logic [23:0] value_data;
        logic        checksum_error;
        logic        gave_up;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/mrpc_cfg_regs.sv =====
// Configuration register bank of the meter register poll controller.
// Depends on mrpc_pkg for the register indexes and the cfg_t type.
`default_nettype none

module mrpc_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mrpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mrpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output mrpc_pkg::cfg_t                       cfg
);

    mrpc_pkg::cfg_t cfg_reg;
    mrpc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                mrpc_pkg::CFG_READ_COMMAND:  cfg_next.read_command      = cfg_data[7:0];
                mrpc_pkg::CFG_CURRENT_ADDR:  cfg_next.current_reg_addr  = cfg_data[7:0];
                mrpc_pkg::CFG_VOLTAGE_ADDR:  cfg_next.voltage_reg_addr  = cfg_data[7:0];
                mrpc_pkg::CFG_TIMEOUT_TICKS: cfg_next.timeout_ticks     = cfg_data[15:0];
                mrpc_pkg::CFG_POLL_PERIOD:   cfg_next.poll_period_ticks = cfg_data[15:0];
                mrpc_pkg::CFG_MAX_RETRIES:   cfg_next.max_retries       = cfg_data[2:0];
                mrpc_pkg::CFG_AUTO_ENABLE:   cfg_next.auto_enable       = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_command      <= 8'd88;
            cfg_reg.current_reg_addr  <= 8'd3;
            cfg_reg.voltage_reg_addr  <= 8'd4;
            cfg_reg.timeout_ticks     <= 16'd200;
            cfg_reg.poll_period_ticks <= 16'd1000;
            cfg_reg.max_retries       <= 3'd5;
            cfg_reg.auto_enable       <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/mrpc_step.sv =====
// Next-state and result logic for one beat of the poll controller.
// Purely combinational; depends on mrpc_pkg for the state, item and result types.
`default_nettype none

module mrpc_step (
    input  mrpc_pkg::cfg_t    cfg,
    input  mrpc_pkg::state_t  state,
    input  mrpc_pkg::item_t   item,
    output mrpc_pkg::state_t  state_next,
    output mrpc_pkg::result_t result
);

    mrpc_pkg::state_t  s;
    mrpc_pkg::result_t r;
    logic [7:0]        sum;
    logic [15:0]       count;
    logic [15:0]       ptimer;

    always_comb
    begin
        s      = state;
        r      = '0;
        sum    = cfg.read_command + state.pending_addr + item.data_high
                 + item.data_mid + item.data_low;
        count  = (state.timer_phase == mrpc_pkg::PHASE_ARMED) ? 16'd1
                 : state.timeout_count + 16'd1;
        ptimer = state.poll_timer + 16'd1;

        case (item.op)
            mrpc_pkg::OP_TICK:
            begin
                if (state.timer_phase != mrpc_pkg::PHASE_IDLE)
                begin
                    s.timer_phase   = mrpc_pkg::PHASE_COUNTING;
                    s.timeout_count = count;
                    if (count >= cfg.timeout_ticks)
                    begin
                        s.timeout_count = '0;
                        s.timer_phase   = mrpc_pkg::PHASE_IDLE;
                        s.timeout_flag  = 1'b1;
                    end
                end
                else
                begin
                    s.timeout_count = '0;
                end
                if (cfg.auto_enable)
                begin
                    s.poll_timer = ptimer;
                    if (ptimer >= cfg.poll_period_ticks)
                    begin
                        s.poll_timer = '0;
                        s.poll_slot  = ~state.poll_slot;
                        s.busy       = 1'b0;
                    end
                end
                else
                begin
                    s.poll_timer = '0;
                end
            end

            mrpc_pkg::OP_FRAME:
            begin
                if (state.busy)
                begin
                    if ((mrpc_pkg::CHECKSUM_BASE - sum) != item.frame_checksum)
                    begin
                        r.checksum_error = 1'b1;
                        if (state.retry_count < cfg.max_retries)
                        begin
                            s.retry_count     = state.retry_count + 3'd1;
                            s.timer_phase     = mrpc_pkg::PHASE_ARMED;
                            s.timeout_flag    = 1'b0;
                            s.busy            = 1'b1;
                            r.request_valid   = 1'b1;
                            r.request_command = cfg.read_command;
                            r.request_addr    = state.pending_addr;
                        end
                        else
                        begin
                            s.timer_phase  = mrpc_pkg::PHASE_IDLE;
                            s.timeout_flag = 1'b0;
                            s.retry_count  = '0;
                            s.busy         = 1'b0;
                            r.gave_up      = 1'b1;
                        end
                    end
                    else
                    begin
                        // Voltage wins when both address registers match.
                        if (state.pending_addr == cfg.voltage_reg_addr)
                        begin
                            r.value_valid   = 1'b1;
                            r.value_channel = 1'b0;
                        end
                        else if (state.pending_addr == cfg.current_reg_addr)
                        begin
                            r.value_valid   = 1'b1;
                            r.value_channel = 1'b1;
                        end
                        if (r.value_valid)
                        begin
                            r.value_data = {item.data_high, item.data_mid, item.data_low};
                        end
                        s.timer_phase  = mrpc_pkg::PHASE_IDLE;
                        s.timeout_flag = 1'b0;
                        s.retry_count  = '0;
                        s.busy         = 1'b0;
                    end
                end
            end

            mrpc_pkg::OP_SERVICE:
            begin
                if (state.timeout_flag)
                begin
                    s.timeout_flag = 1'b0;
                    if (state.retry_count < cfg.max_retries)
                    begin
                        s.retry_count     = state.retry_count + 3'd1;
                        s.timer_phase     = mrpc_pkg::PHASE_ARMED;
                        s.busy            = 1'b1;
                        r.request_valid   = 1'b1;
                        r.request_command = cfg.read_command;
                        r.request_addr    = state.pending_addr;
                    end
                    else
                    begin
                        s.timer_phase = mrpc_pkg::PHASE_IDLE;
                        s.retry_count = '0;
                        s.busy        = 1'b0;
                        r.gave_up     = 1'b1;
                    end
                end
                // A give-up above and a fresh read here can share one result.
                if (!s.busy)
                begin
                    s.pending_addr    = state.poll_slot ? cfg.voltage_reg_addr
                                                        : cfg.current_reg_addr;
                    s.retry_count     = '0;
                    s.timer_phase     = mrpc_pkg::PHASE_ARMED;
                    s.timeout_flag    = 1'b0;
                    s.busy            = 1'b1;
                    r.request_valid   = 1'b1;
                    r.request_command = cfg.read_command;
                    r.request_addr    = s.pending_addr;
                end
            end

            default:
            begin
                s = state;
            end
        endcase
    end

    assign state_next = s;
    assign result     = r;

endmodule

`default_nettype wire

// ===== hdl/meter_register_poll_controller.sv =====
// Top level of the meter register poll controller: input register, step logic,
// result register. Depends on mrpc_pkg, mrpc_cfg_regs, mrpc_step and the assert header.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+------------------------------------------------
//  input   | in_valid / in_ready       | op, data_high, data_mid, data_low, frame_checksum
//  output  | out_valid / out_ready     | request_*, value_*, checksum_error, gave_up
//  config  | cfg_wr_en (no wait)       | cfg_index, cfg_data
//
// An accepted beat is held in the input register; the step logic then updates the state
// and loads the result register. One beat per cycle is sustained while the output
// does not stall; the single step stage sets that figure.
// A stalled output holds the result register and then the input register; the
// input side stalls only when both are full. Reset clears state and sets config defaults.
`default_nettype none

`include "meter_register_poll_controller_assert.svh"

module meter_register_poll_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      op,
    input  wire logic [7:0]                      data_high,
    input  wire logic [7:0]                      data_mid,
    input  wire logic [7:0]                      data_low,
    input  wire logic [7:0]                      frame_checksum,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 request_valid,
    output logic [7:0]                           request_command,
    output logic [7:0]                           request_addr,
    output logic                                 value_valid,
    output logic                                 value_channel,
    output logic [23:0]                          value_data,
    output logic                                 checksum_error,
    output logic                                 gave_up,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mrpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mrpc_pkg::CFG_DATA_W-1:0] cfg_data
);

    mrpc_pkg::cfg_t    cfg;
    mrpc_pkg::item_t   item_reg;
    mrpc_pkg::item_t   item_next;
    logic              in_valid_reg;
    logic              in_valid_next;
    mrpc_pkg::state_t  state_reg;
    mrpc_pkg::state_t  state_next;
    mrpc_pkg::state_t  step_state;
    mrpc_pkg::result_t step_result;
    mrpc_pkg::result_t result_reg;
    mrpc_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              in_accept;
    logic              fire;

    mrpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mrpc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    // A beat moves on from the input register when the result register is free.
    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        item_next      = in_accept ? {op, data_high, data_mid, data_low, frame_checksum}
                                   : item_reg;
        in_valid_next  = in_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        state_next     = fire ? step_state : state_reg;
        result_next    = fire ? step_result : result_reg;
        out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign request_valid   = result_reg.request_valid;
    assign request_command = result_reg.request_command;
    assign request_addr    = result_reg.request_addr;
    assign value_valid     = result_reg.value_valid;
    assign value_channel   = result_reg.value_channel;
    assign value_data      = result_reg.value_data;
    assign checksum_error  = result_reg.checksum_error;
    assign gave_up         = result_reg.gave_up;

    `MRPC_ASSERT_NEXT(a_fire_loads_result, clk, rst_n, fire, out_valid_reg)
    `MRPC_ASSERT_NEXT(a_held_beat_stays, clk, rst_n, in_valid_reg && !fire, in_valid_reg)
    `MRPC_ASSERT_SAME(a_value_excludes_request, clk, rst_n, out_valid_reg && value_valid, !request_valid && !checksum_error && !gave_up)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for meter_register_poll_controller: a beat-level model of the
// poll, timeout and retry logic predicts every result beat, compared field by field.
// Depends on mrpc_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module testbench;

    import mrpc_pkg::*;

    localparam logic [1:0]           OP_UNUSED        = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam logic                 CH_VOLTAGE       = 1'b0;
    localparam logic                 CH_CURRENT       = 1'b1;

    localparam int unsigned CYCLE_LIMIT    = 300000;
    localparam int unsigned HOLD_CYCLES    = 120;
    localparam int unsigned RECONFIG_BEATS = 135;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            op;
    logic [7:0]            data_high;
    logic [7:0]            data_mid;
    logic [7:0]            data_low;
    logic [7:0]            frame_checksum;
    logic                  out_valid;
    logic                  out_ready;
    logic                  request_valid;
    logic [7:0]            request_command;
    logic [7:0]            request_addr;
    logic                  value_valid;
    logic                  value_channel;
    logic [23:0]           value_data;
    logic                  checksum_error;
    logic                  gave_up;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Model copy of the registers and the controller state.
    cfg_t        pcfg;
    state_t      pstate;
    result_t     poll_out;
    result_t     step_results[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_rx;

    meter_register_poll_controller u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .data_high       (data_high),
        .data_mid        (data_mid),
        .data_low        (data_low),
        .frame_checksum  (frame_checksum),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .request_valid   (request_valid),
        .request_command (request_command),
        .request_addr    (request_addr),
        .value_valid     (value_valid),
        .value_channel   (value_channel),
        .value_data      (value_data),
        .checksum_error  (checksum_error),
        .gave_up         (gave_up),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Controller model
    // ---------------------------------------------------------------------------------

    // Checksum a frame must carry for the read now outstanding.
    function automatic logic [7:0] frame_sum(input logic [7:0] hi, input logic [7:0] mid,
                                             input logic [7:0] lo);
        logic [7:0] total;
        total = pcfg.read_command + pstate.pending_addr + hi + mid + lo;
        return CHECKSUM_BASE - total;
    endfunction

    function automatic void issue_read();
        pstate.timer_phase      = PHASE_ARMED;
        pstate.timeout_flag     = 1'b0;
        pstate.busy             = 1'b1;
        poll_out.request_valid   = 1'b1;
        poll_out.request_command = pcfg.read_command;
        poll_out.request_addr    = pstate.pending_addr;
    endfunction

    function automatic void end_read();
        pstate.timer_phase  = PHASE_IDLE;
        pstate.timeout_flag = 1'b0;
        pstate.retry_count  = '0;
        pstate.busy         = 1'b0;
    endfunction

    function automatic void retry_or_give_up();
        if (pstate.retry_count < pcfg.max_retries)
        begin
            pstate.retry_count = pstate.retry_count + 3'd1;
            issue_read();
        end
        else
        begin
            end_read();
            poll_out.gave_up = 1'b1;
        end
    endfunction

    function automatic result_t poll_step(input item_t it);
        poll_out = '0;
        case (it.op)
            OP_TICK:
            begin
                if (pstate.timer_phase != PHASE_IDLE)
                begin
                    // An armed timeout starts counting from zero on its first tick.
                    if (pstate.timer_phase == PHASE_ARMED)
                    begin
                        pstate.timer_phase   = PHASE_COUNTING;
                        pstate.timeout_count = '0;
                    end
                    pstate.timeout_count = pstate.timeout_count + 16'd1;
                    if (pstate.timeout_count >= pcfg.timeout_ticks)
                    begin
                        pstate.timeout_count = '0;
                        pstate.timer_phase   = PHASE_IDLE;
                        pstate.timeout_flag  = 1'b1;
                    end
                end
                else
                begin
                    pstate.timeout_count = '0;
                end
                if (pcfg.auto_enable)
                begin
                    pstate.poll_timer = pstate.poll_timer + 16'd1;
                    if (pstate.poll_timer >= pcfg.poll_period_ticks)
                    begin
                        pstate.poll_timer = '0;
                        pstate.poll_slot  = ~pstate.poll_slot;
                        pstate.busy       = 1'b0;
                    end
                end
                else
                begin
                    pstate.poll_timer = '0;
                end
            end
            OP_FRAME:
            begin
                if (pstate.busy)
                begin
                    if (frame_sum(it.data_high, it.data_mid, it.data_low) != it.frame_checksum)
                    begin
                        poll_out.checksum_error = 1'b1;
                        retry_or_give_up();
                    end
                    else
                    begin
                        // The voltage register wins when both addresses match.
                        if (pstate.pending_addr == pcfg.voltage_reg_addr)
                        begin
                            poll_out.value_valid   = 1'b1;
                            poll_out.value_channel = CH_VOLTAGE;
                        end
                        else if (pstate.pending_addr == pcfg.current_reg_addr)
                        begin
                            poll_out.value_valid   = 1'b1;
                            poll_out.value_channel = CH_CURRENT;
                        end
                        if (poll_out.value_valid)
                            poll_out.value_data = {it.data_high, it.data_mid, it.data_low};
                        end_read();
                    end
                end
            end
            OP_SERVICE:
            begin
                if (pstate.timeout_flag)
                begin
                    pstate.timeout_flag = 1'b0;
                    retry_or_give_up();
                end
                if (!pstate.busy)
                begin
                    pstate.pending_addr = pstate.poll_slot ? pcfg.voltage_reg_addr
                                                           : pcfg.current_reg_addr;
                    pstate.retry_count  = '0;
                    issue_read();
                end
            end
            default:
            begin
            end
        endcase
        return poll_out;
    endfunction

    // ---------------------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [23:0] want,
                                          input logic [23:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {request_valid, request_command, request_addr, value_valid,
                   value_channel, value_data, checksum_error, gave_up};
            if (step_results.size() == 0)
            begin
                mismatch_count++;
                $error("result beat arrived with no step outstanding");
            end
            else
            begin
                want = step_results.pop_front();
                compare_field("request_valid", 24'(want.request_valid),
                              24'(got.request_valid));
                compare_field("request_command", 24'(want.request_command),
                              24'(got.request_command));
                compare_field("request_addr", 24'(want.request_addr),
                              24'(got.request_addr));
                compare_field("value_valid", 24'(want.value_valid),
                              24'(got.value_valid));
                compare_field("value_channel", 24'(want.value_channel),
                              24'(got.value_channel));
                compare_field("value_data", want.value_data, got.value_data);
                compare_field("checksum_error", 24'(want.checksum_error),
                              24'(got.checksum_error));
                compare_field("gave_up", 24'(want.gave_up), 24'(got.gave_up));
            end
        end
        out_ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------------------

    // Valid is left high after a beat so back-to-back beats need no second assignment;
    // anything other than another send must lower it first.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= it.op;
        data_high      <= it.data_high;
        data_mid       <= it.data_mid;
        data_low       <= it.data_low;
        frame_checksum <= it.frame_checksum;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        step_results.push_back(poll_step(it));
    endtask

    task automatic send_good_frame(input logic [7:0] hi, input logic [7:0] mid,
                                   input logic [7:0] lo);
        send_item({OP_FRAME, hi, mid, lo, frame_sum(hi, mid, lo)});
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (step_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_READ_COMMAND:  pcfg.read_command      = value[7:0];
            CFG_CURRENT_ADDR:  pcfg.current_reg_addr  = value[7:0];
            CFG_VOLTAGE_ADDR:  pcfg.voltage_reg_addr  = value[7:0];
            CFG_TIMEOUT_TICKS: pcfg.timeout_ticks     = value;
            CFG_POLL_PERIOD:   pcfg.poll_period_ticks = value;
            CFG_MAX_RETRIES:   pcfg.max_retries       = value[2:0];
            CFG_AUTO_ENABLE:   pcfg.auto_enable       = value[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic write_single(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        drain_results();
        write_reg(idx, value);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic randomize_config(input bit deep_retries);
        logic [7:0] cur;
        cur = 8'($urandom_range(255));
        drain_results();
        write_reg(CFG_READ_COMMAND, 16'($urandom_range(255)));
        write_reg(CFG_CURRENT_ADDR, {8'h00, cur});
        write_reg(CFG_VOLTAGE_ADDR, ($urandom_range(7) == 0) ? {8'h00, cur}
                                                            : 16'($urandom_range(255)));
        // Short timeouts keep the retry path busy; a long one now and then lets reads
        // complete only by frame.
        write_reg(CFG_TIMEOUT_TICKS, ($urandom_range(7) == 0)
                                     ? 16'($urandom_range(65535, 1000))
                                     : 16'($urandom_range(6, 1)));
        write_reg(CFG_POLL_PERIOD, ($urandom_range(9) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(40, 1)));
        write_reg(CFG_MAX_RETRIES, deep_retries ? 16'd7 : 16'($urandom_range(7)));
        write_reg(CFG_AUTO_ENABLE, {15'd0, ($urandom_range(4) != 0)});
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed traffic: service steps start reads, frames answer them.
    function automatic item_t random_item(input int unsigned good_pct);
        item_t       it;
        int unsigned pick;
        pick              = $urandom_range(99);
        it.data_high      = 8'($urandom_range(255));
        it.data_mid       = 8'($urandom_range(255));
        it.data_low       = 8'($urandom_range(255));
        it.frame_checksum = 8'($urandom_range(255));
        if (pstate.busy)
        begin
            if (pick < 45)
            begin
                it.op = OP_FRAME;
                if ($urandom_range(99) < good_pct)
                    it.frame_checksum = frame_sum(it.data_high, it.data_mid, it.data_low);
            end
            else if (pick < 75)
                it.op = OP_TICK;
            else if (pick < 97)
                it.op = OP_SERVICE;
            else
                it.op = OP_UNUSED;
        end
        else
        begin
            if (pick < 45)
                it.op = OP_SERVICE;
            else if (pick < 85)
                it.op = OP_TICK;
            else if (pick < 95)
                it.op = OP_FRAME;
            else
                it.op = OP_UNUSED;
        end
        return it;
    endfunction

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    task automatic test_reset_defaults();
        send_item({OP_FRAME, 32'hFFFF_FF00});
        send_item({OP_UNUSED, 32'hFFFF_FFFF});
        send_item({OP_SERVICE, 32'h0});
        send_item({OP_FRAME, 8'h12, 8'h34, 8'h56, frame_sum(8'h12, 8'h34, 8'h56) ^ 8'h01});
        send_good_frame(8'hFF, 8'hFF, 8'hFF);
        send_item({OP_SERVICE, 32'h0});
        send_good_frame(8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_timeout_and_give_up();
        drain_results();
        write_reg(CFG_READ_COMMAND, 16'h00FF);
        write_reg(CFG_CURRENT_ADDR, 16'h0000);
        write_reg(CFG_VOLTAGE_ADDR, 16'h00FF);
        write_reg(CFG_TIMEOUT_TICKS, 16'd1);
        write_reg(CFG_POLL_PERIOD, 16'hFFFF);
        write_reg(CFG_MAX_RETRIES, 16'd0);
        cfg_wr_en <= 1'b0;
        // With no retries allowed each timeout gives up and restarts in one beat.
        send_item({OP_SERVICE, 32'h0});
        repeat (2)
        begin
            send_item({OP_TICK, 32'h0});
            send_item({OP_SERVICE, 32'h0});
        end
        write_single(CFG_MAX_RETRIES, 16'd1);
        repeat (2)
        begin
            send_item({OP_TICK, 32'h0});
            send_item({OP_SERVICE, 32'h0});
        end
    endtask

    task automatic test_slot_rotation();
        drain_results();
        write_reg(CFG_READ_COMMAND, 16'h0000);
        write_reg(CFG_CURRENT_ADDR, 16'h005A);
        write_reg(CFG_VOLTAGE_ADDR, 16'h00A5);
        write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
        write_reg(CFG_POLL_PERIOD, 16'd1);
        cfg_wr_en <= 1'b0;
        send_item({OP_TICK, 32'h0});
        send_item({OP_SERVICE, 32'h0});
        send_good_frame(8'h80, 8'h00, 8'h01);
        write_single(CFG_AUTO_ENABLE, 16'd0);
        send_item({OP_TICK, 32'h0});
        send_item({OP_SERVICE, 32'h0});
    endtask

    task automatic test_address_match();
        // The outstanding read's address no longer matches either register.
        drain_results();
        write_reg(CFG_CURRENT_ADDR, 16'h0077);
        write_reg(CFG_VOLTAGE_ADDR, 16'h0077);
        write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        cfg_wr_en <= 1'b0;
        send_good_frame(8'h01, 8'h02, 8'h03);
        send_item({OP_SERVICE, 32'h0});
        send_good_frame(8'hAB, 8'hCD, 8'hEF);
    endtask

    task automatic test_output_backpressure();
        randomize_config(1'b0);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx <= 1'b0;
            end
        join_none
        repeat (24) send_item(random_item(50));
    endtask

    task automatic test_random_polling(input int unsigned beats, input int unsigned send_pct,
                                       input int unsigned recv_pct, input bit deep_retries);
        item_t       it;
        int unsigned done;
        int unsigned next_cfg;
        int unsigned good_pct;
        done     = 0;
        next_cfg = 0;
        good_pct = 50;
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        while (done < beats)
        begin
            if (done >= next_cfg)
            begin
                randomize_config(deep_retries && next_cfg == 0);
                case ($urandom_range(2))
                    0:       good_pct = 15;
                    1:       good_pct = 50;
                    default: good_pct = 85;
                endcase
                next_cfg = next_cfg + RECONFIG_BEATS;
            end
            it = random_item(good_pct);
            done++;
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        op             <= OP_TICK;
        data_high      <= '0;
        data_mid       <= '0;
        data_low       <= '0;
        frame_checksum <= '0;
        out_ready      <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        hold_rx        <= 1'b0;
        recv_idle_pct  <= 0;
        send_idle_pct  = 0;
        pcfg   = {8'd88, 8'd3, 8'd4, 16'd200, 16'd1000, 3'd5, 1'b1};
        pstate = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_timeout_and_give_up();
        test_slot_rotation();
        test_address_match();
        test_output_backpressure();
        test_random_polling(540, 11, 85, 1'b1);
        test_random_polling(540, 85, 11, 1'b0);
        test_random_polling(540, 0, 0, 1'b0);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== meter_register_poll_controller.f =====
+incdir+hdl
hdl/mrpc_pkg.sv
hdl/mrpc_cfg_regs.sv
hdl/mrpc_step.sv
hdl/meter_register_poll_controller.sv
tb/testbench.sv
